>>> hw/rtl/slc_pkg.sv
// Shared types, register codes and table builder for the scaled log10 converter.
// No dependencies.
`timescale 1ns / 1ps
package slc_pkg;

  typedef enum logic {
    REG_GAIN   = 1'b0,
    REG_OFFSET = 1'b1
  } slc_reg_t;

  typedef struct packed {
    logic [31:0] x;
    logic [4:0]  p;
    logic        zero;
    logic        blk_end;
  } slc_norm_t;

  // log2(1 + i/2^tb) in Q0.fb by repeated squaring, rounded
  function automatic logic [63:0] frac_entry(input int i, input int tb, input int fb);
    logic [63:0] y;
    logic [63:0] r;
    y = (64'(1 << tb) + 64'(i)) << (31 - tb);
    r = '0;
    for (int b = 0; b < fb + 1; b++) begin
      y = (y * y) >> 31;
      r = r << 1;
      if (y >= 64'h1_0000_0000) begin
        r = r | 64'd1;
        y = y >> 1;
      end
    end
    return (r + 64'd1) >> 1;
  endfunction

endpackage

>>> hw/rtl/slc_if.sv
// Beat interfaces for the sample and result channels.
// Depends on nothing.
`timescale 1ns / 1ps
interface slc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample;
  logic        block_end;
  modport source (output valid, sample, block_end, input ready);
  modport sink (input valid, sample, block_end, output ready);
endinterface

interface slc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] level;
  logic               zero_input;
  logic               block_end_out;
  modport source (output valid, level, zero_input, block_end_out, input ready);
  modport sink (input valid, level, zero_input, block_end_out, output ready);
endinterface

>>> hw/rtl/slc_norm_cell.sv
// One normalising cell: shifts out SHIFT leading zeros when present.
// Depends on slc_pkg.
`timescale 1ns / 1ps
module slc_norm_cell #(
  parameter int SHIFT = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  output logic              in_rdy,
  input  slc_pkg::slc_norm_t in_d,
  output logic              out_vld,
  input  logic              out_rdy,
  output slc_pkg::slc_norm_t out_d
);
  import slc_pkg::*;

  logic      vld_r;
  slc_norm_t d_r, d_nxt;

  assign in_rdy  = !vld_r || out_rdy;
  assign out_vld = vld_r;
  assign out_d   = d_r;

  always_comb begin
    d_nxt = in_d;
    if (in_d.x[31 -: SHIFT] == '0) begin
      d_nxt.x = in_d.x << SHIFT;
      d_nxt.p = in_d.p - 5'(SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      d_r <= d_nxt;
    end
  end
endmodule

>>> hw/rtl/slc_log_core.sv
// Table interpolation, log10 scaling, gain, offset and saturation stages.
// Depends on slc_pkg.
`timescale 1ns / 1ps
module slc_log_core #(
  parameter int TABLE_BITS    = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  output logic               in_rdy,
  input  slc_pkg::slc_norm_t in_d,
  input  logic signed [15:0] gain,
  input  logic signed [31:0] offset,
  output logic               out_vld,
  input  logic               out_rdy,
  output logic signed [31:0] out_level,
  output logic               out_zero,
  output logic               out_end
);
  import slc_pkg::*;

  localparam int T    = TABLE_BITS;
  localparam int F    = FRACTION_BITS;
  localparam int RW   = 31 - T;
  localparam int LW   = F + 6;
  localparam int MW   = LW + 31;
  localparam int DW   = F + 5;
  localparam int PW   = DW + 16;
  localparam int SG   = F - 8;
  localparam int SW   = ((PW > 32) ? PW : 32) + 1;
  localparam logic signed [30:0] LOG10_2 = 31'sd323228497;
  localparam logic signed [MW-1:0] HALF30 = MW'(64'd1 << 29);
  localparam logic signed [PW-1:0] HALFG  = (SG > 0) ? PW'(64'd1 << (SG - 1)) : '0;
  localparam logic signed [SW-1:0] SMAX   = SW'(33'sh0_7FFF_FFFF);
  localparam logic signed [SW-1:0] SMIN   = SW'(33'sh1_8000_0000);

  logic [F:0] rom [0:(1 << T)];
  for (genvar gi = 0; gi <= (1 << T); gi++) begin : g_rom
    localparam logic [63:0] EV = (gi == (1 << T)) ? (64'd1 << F) : frac_entry(gi, T, F);
    assign rom[gi] = EV[F:0];
  end

  logic [4:0] vld_r;
  logic [5:0] adv;
  logic       zr_r [0:4];
  logic       ed_r [0:4];

  assign adv[5] = out_rdy;
  for (genvar k = 0; k < 5; k++) begin : g_adv
    assign adv[k] = !vld_r[k] || adv[k+1];
  end
  assign in_rdy  = adv[0];
  assign out_vld = vld_r[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_vld;
      end
      for (int k = 1; k < 5; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // zero and block-end flags ride alongside
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      zr_r[0] <= in_d.zero;
      ed_r[0] <= in_d.blk_end;
    end
    for (int k = 1; k < 5; k++) begin
      if (adv[k]) begin
        zr_r[k] <= zr_r[k-1];
        ed_r[k] <= ed_r[k-1];
      end
    end
  end

  // stage A: table read
  logic [T-1:0]  idx;
  logic [F:0]    t0_r, dif_r;
  logic [RW-1:0] rem_r;
  logic [4:0]    pa_r;
  assign idx = in_d.x[30 -: T];
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      t0_r  <= rom[idx];
      dif_r <= rom[(T+1)'(idx) + (T+1)'(1)] - rom[idx];
      rem_r <= in_d.x[RW-1:0];
      pa_r  <= in_d.p;
    end
  end

  // stage B: interpolation, log2
  logic [F+RW:0]        mul;
  logic [F:0]           frac;
  logic signed [5:0]    ps;
  logic signed [LW-1:0] lg_r;
  assign mul  = (F+RW+1)'(dif_r) * (F+RW+1)'(rem_r);
  assign frac = t0_r + (F+1)'(mul >> RW);
  assign ps   = $signed({1'b0, pa_r}) - 6'sd16;
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      lg_r <= (LW'(ps) <<< F) + $signed(LW'(frac));
    end
  end

  // stage C: times log10(2)
  logic signed [MW-1:0] ml;
  logic signed [DW-1:0] d_r;
  assign ml = MW'(lg_r) * MW'(LOG10_2);
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      d_r <= DW'((ml + HALF30) >>> 30);
    end
  end

  // stage D: gain
  logic signed [PW-1:0] mg;
  logic signed [PW-1:0] pg_r;
  assign mg = PW'(gain) * PW'(d_r);
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      pg_r <= (mg + HALFG) >>> SG;
    end
  end

  // stage E: offset and saturation
  logic signed [SW-1:0] sum;
  logic signed [31:0]   lvl_r;
  assign sum = SW'(pg_r) + SW'(offset);
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      if (zr_r[3] || sum < SMIN) begin
        lvl_r <= 32'sh8000_0000;
      end else if (sum > SMAX) begin
        lvl_r <= 32'sh7FFF_FFFF;
      end else begin
        lvl_r <= sum[31:0];
      end
    end
  end

  assign out_level = lvl_r;
  assign out_zero  = zr_r[4];
  assign out_end   = ed_r[4];
endmodule

>>> hw/rtl/scaled_log10_converter.sv
// Top level: config registers, normalising cell row and log core.
// Depends on slc_pkg, slc_if, slc_norm_cell, slc_log_core.
//
//   channel  dir  beat fields
//   in_ch    in   sample[31:0] block_end
//   out_ch   out  level[31:0] zero_input block_end_out
//   cfg_*    in   cfg_we cfg_idx cfg_data[31:0]
//
// One beat per cycle sustained while out_ch.ready is high; 5 normalising cells, 5 core stages.
// Each stage has its own valid; ready ripples back so bubbles are squeezed out.
// Reset (sync, rst_n low) empties the pipe and loads gain 10.0, offset 0.
`timescale 1ns / 1ps
module scaled_log10_converter #(
  parameter int TABLE_BITS    = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  slc_in_if.sink          in_ch,
  slc_out_if.source       out_ch,
  input  logic            cfg_we,
  input  slc_pkg::slc_reg_t cfg_idx,
  input  logic [31:0]     cfg_data
);
  import slc_pkg::*;

  logic signed [15:0] gain_r;
  logic signed [31:0] offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= 16'sd2560;
      offset_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_GAIN:   gain_r   <= cfg_data[15:0];
        REG_OFFSET: offset_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  logic      vld [0:5];
  logic      rdy [0:5];
  slc_norm_t dat [0:5];

  assign vld[0]      = in_ch.valid;
  assign in_ch.ready = rdy[0];
  assign dat[0]      = '{x: in_ch.sample, p: 5'd31, zero: (in_ch.sample == '0),
                         blk_end: in_ch.block_end};

  for (genvar gi = 0; gi < 5; gi++) begin : g_cell
    slc_norm_cell #(.SHIFT(16 >> gi)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_vld(vld[gi]), .in_rdy(rdy[gi]), .in_d(dat[gi]),
      .out_vld(vld[gi+1]), .out_rdy(rdy[gi+1]), .out_d(dat[gi+1])
    );
  end

  slc_log_core #(.TABLE_BITS(TABLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_core (
    .clk(clk), .rst_n(rst_n),
    .in_vld(vld[5]), .in_rdy(rdy[5]), .in_d(dat[5]),
    .gain(gain_r), .offset(offset_r),
    .out_vld(out_ch.valid), .out_rdy(out_ch.ready),
    .out_level(out_ch.level), .out_zero(out_ch.zero_input),
    .out_end(out_ch.block_end_out)
  );
endmodule

>>> hw/rtl/slc_checker.sv
// Port-level checks for scaled_log10_converter, attached by bind.
// Depends on scaled_log10_converter and slc_if.
`timescale 1ns / 1ps
module slc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] level,
  input logic        zero_input
);
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");
  a_zero_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_input |-> level == 32'h8000_0000)
    else $error("zero sample without minimum level");
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input held off while output drains");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(level))
    else $error("stalled result changed");
endmodule

bind scaled_log10_converter slc_checker u_slc_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .level(out_ch.level), .zero_input(out_ch.zero_input)
);
